// File: rtl/core/ic_pkg.sv
// ----------------------------------------------------------------------------
// ic_pkg: shared types and constants of the interrupt coalescer
// Command broadcast to the vector cells, the priority link between cells,
// register indexes and operation codes.
// ----------------------------------------------------------------------------
package ic_pkg;

  localparam int VEC_W   = 5;
  localparam int TIME_W  = 64;
  localparam int COUNT_W = 16;

  localparam logic [TIME_W-1:0]  DISARMED  = {TIME_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // operation codes of an input item
  localparam logic OP_POST = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // configuration register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_TIME      = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_ENABLE    = 2'd2
  } ic_reg_t;

  // command broadcast to every cell in the cycle an item is accepted
  typedef struct packed {
    logic               tick;
    logic               post;
    logic               hold;        // post is coalesced (valid setup, lane enabled)
    logic               assert_req;
    logic [VEC_W-1:0]   vector;
    logic [TIME_W-1:0]  time_next;
    logic [TIME_W-1:0]  arm_deadline;
    logic [COUNT_W-1:0] threshold;
  } ic_cmd_t;

  // priority link handed up the chain: lowest cell with an expired flag
  typedef struct packed {
    logic             found;
    logic [VEC_W-1:0] idx;
  } ic_link_t;

endpackage

// File: rtl/core/interrupt_coalescer_unit.sv
// ----------------------------------------------------------------------------
// interrupt_coalescer_unit: per-vector interrupt coalescing
// Row of vector cells behind a broadcast command bus, APB register port and
// an output register.
// ----------------------------------------------------------------------------
// A post item gives at most one result, which is written to the output
// register as the item is accepted. A tick item updates time and compares
// every deadline at once; expired cells are flagged and drained one per cycle
// while the output is not stalled, lowest vector first, through the priority
// link that runs along the cell row; no item is accepted until the drain is
// done. A stalled output also holds off the input. Vectors at or above
// NUM_VECTORS (or 32) are never coalesced and pass straight through.
module interrupt_coalescer_unit
  import ic_pkg::*;
#(
  parameter int NUM_VECTORS = 32
) (
  input  logic             clk,
  input  logic             rst,
  // item input
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             operation,
  input  logic [VEC_W-1:0] vector,
  input  logic             assert_req,
  // result output
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VEC_W-1:0] out_vector,
  output logic             out_assert,
  output logic             last,
  // register port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int LANES = (NUM_VECTORS < 32) ? NUM_VECTORS : 32;

  logic [31:0]        coalesce_time;
  logic [COUNT_W-1:0] coalesce_threshold;
  logic [31:0]        enable_mask;
  logic [TIME_W-1:0]  current_time;

  logic               wr_en;
  ic_reg_t            reg_sel;
  logic [31:0]        mask_changed;
  logic               accept, out_free, drain_busy, take;
  logic               setup_ok, lane_ok, hold, post_emit;
  ic_cmd_t            cmd;
  ic_link_t           link [0:LANES];
  logic [LANES-1:0]   flags, emits, clr;

  // register port
  assign pready  = 1'b1;
  assign reg_sel = ic_reg_t'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    case (reg_sel)
      REG_TIME:      prdata = coalesce_time;
      REG_THRESHOLD: prdata = {16'b0, coalesce_threshold};
      REG_ENABLE:    prdata = enable_mask;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coalesce_time      <= '0;
      coalesce_threshold <= '0;
      enable_mask        <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_TIME:      coalesce_time      <= pwdata;
        REG_THRESHOLD: coalesce_threshold <= pwdata[COUNT_W-1:0];
        REG_ENABLE:    enable_mask        <= pwdata;
        default:       ;
      endcase
    end
  end

  // entries whose enable bit changes are cleared
  assign mask_changed = (wr_en && reg_sel == REG_ENABLE) ? (enable_mask ^ pwdata) : '0;
  assign clr          = mask_changed[LANES-1:0];

  // handshake
  assign out_free   = ~out_valid | ~out_stall;
  assign drain_busy = |flags;
  assign in_stall   = drain_busy | ~out_free;
  assign accept     = in_valid & ~in_stall;
  assign take       = drain_busy & out_free;

  // post classification
  assign setup_ok = (coalesce_time != '0) && (coalesce_threshold >= COUNT_W'(2));
  assign lane_ok  = ({1'b0, vector} < (VEC_W + 1)'(LANES));
  assign hold     = setup_ok & lane_ok & enable_mask[vector];

  // command broadcast to the cells
  always_comb begin
    cmd.tick         = accept & (operation == OP_TICK);
    cmd.post         = accept & (operation == OP_POST);
    cmd.hold         = hold;
    cmd.assert_req   = assert_req;
    cmd.vector       = vector;
    cmd.time_next    = current_time + TIME_W'(1);
    cmd.arm_deadline = current_time + TIME_W'(coalesce_time);
    cmd.threshold    = coalesce_threshold;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
    end else if (cmd.tick) begin
      current_time <= cmd.time_next;
    end
  end

  // cell row
  assign link[0] = '0;

  for (genvar i = 0; i < LANES; i++) begin : g_cell
    ic_cell #(
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .en       (enable_mask[i]),
      .clr      (clr[i]),
      .take     (take),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .flag_o   (flags[i]),
      .emit     (emits[i])
    );
  end

  // a post gives a result when passed through or when its cell signals
  assign post_emit = cmd.post & (~hold | (|emits));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (post_emit || take) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post_emit) begin
      out_vector <= vector;
      out_assert <= assert_req;
      last       <= 1'b1;
    end else if (take) begin
      out_vector <= link[LANES].idx;
      out_assert <= 1'b1;
      last       <= ((flags & (flags - LANES'(1))) == '0);
    end
  end

endmodule

// File: rtl/core/ic_cell.sv
// ----------------------------------------------------------------------------
// ic_cell: coalescing entry of one interrupt vector
// Holds request count, deadline, pending and expired flags; takes the
// broadcast command and passes the priority link on to the next cell.
// ----------------------------------------------------------------------------
module ic_cell
  import ic_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic     clk,
  input  logic     rst,
  input  ic_cmd_t  cmd,
  input  logic     en,
  input  logic     clr,
  input  logic     take,
  input  ic_link_t link_in,
  output ic_link_t link_out,
  output logic     flag_o,
  output logic     emit
);

  localparam logic [VEC_W-1:0] MY_VEC = VEC_W'(IDX);

  logic [COUNT_W-1:0] count, count_next, cnt_inc;
  logic [TIME_W-1:0]  deadline, deadline_next;
  logic               pending, pending_next;
  logic               flag, flag_next;
  logic               hit, grant, expire;

  assign hit    = cmd.post & cmd.hold & en & (cmd.vector == MY_VEC);
  assign grant  = flag & ~link_in.found;
  assign expire = (deadline != DISARMED) && (deadline == cmd.time_next);
  assign cnt_inc = (count == COUNT_MAX) ? count : count + COUNT_W'(1);

  // priority link: lowest flagged cell wins
  assign link_out.found = link_in.found | flag;
  assign link_out.idx   = link_in.found ? link_in.idx : MY_VEC;
  assign flag_o         = flag;

  // entry update
  always_comb begin
    count_next    = count;
    deadline_next = deadline;
    pending_next  = pending;
    flag_next     = flag;
    emit          = 1'b0;
    if (take && grant) begin
      flag_next = 1'b0;
    end
    if (clr) begin
      count_next    = '0;
      deadline_next = DISARMED;
      pending_next  = 1'b0;
    end else if (cmd.tick) begin
      if (expire) begin
        count_next    = '0;
        deadline_next = DISARMED;
        pending_next  = 1'b1;
        flag_next     = 1'b1;
      end
    end else if (hit) begin
      if (cmd.assert_req) begin
        count_next = cnt_inc;
        if (cnt_inc == COUNT_W'(1)) begin
          deadline_next = cmd.arm_deadline;
        end else if (cnt_inc >= cmd.threshold) begin
          count_next    = '0;
          deadline_next = DISARMED;
          pending_next  = 1'b1;
          emit          = 1'b1;
        end
      end else if (pending) begin
        pending_next = 1'b0;
        emit         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      deadline <= DISARMED;
      pending  <= 1'b0;
      flag     <= 1'b0;
    end else begin
      count    <= count_next;
      deadline <= deadline_next;
      pending  <= pending_next;
      flag     <= flag_next;
    end
  end

endmodule
